// ----- src/plid_pkg.sv -----
// shared types and constants for the positional list block
// no dependencies
package plid_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int OP_W         = 2;
  localparam int POS_W        = 6;
  localparam int VAL_W        = 32;
  localparam int ST_W         = 2;
  localparam int CNT_OUT_W    = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic ins;
    logic del;
    logic single;
    logic dump_start;
    logic dump_step;
  } plid_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic count_zero;
    logic dump_last;
  } plid_stat_t;

endpackage

// ----- src/plid_ctrl.sv -----
// controller state machine for the positional list block
// depends on plid_pkg
module plid_ctrl import plid_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  input  logic            out_stall,
  input  plid_stat_t      stat,
  output logic            in_stall,
  output plid_cmd_t       cmd
);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t state_r, state_nxt;
  logic   out_busy;
  logic   accept;

  assign out_busy = stat.out_valid && out_stall;
  assign in_stall = (state_r != S_IDLE) || out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INSERT: cmd.ins = 1'b1;
            OP_DELETE: cmd.del = 1'b1;
            OP_DUMP: begin
              if (stat.count_zero) begin
                cmd.single = 1'b1;
              end else begin
                cmd.dump_start = 1'b1;
                state_nxt      = S_DUMP;
              end
            end
            default: cmd.single = 1'b1;
          endcase
        end
      end
      S_DUMP: begin
        if (!out_busy) begin
          cmd.dump_step = 1'b1;
          if (stat.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/plid_dp.sv -----
// datapath: element cells, length counter, dump index and output register
// depends on plid_pkg
module plid_dp import plid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  plid_cmd_t               cmd,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_stall,
  output plid_stat_t              stat,
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_element,
  output logic [CNT_OUT_W-1:0]    out_count,
  output logic                    out_last
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic signed [VAL_W-1:0] slots_r [CAPACITY];
  logic signed [VAL_W-1:0] slots_nxt [CAPACITY];
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_element_r, out_element_nxt;
  logic [CNT_OUT_W-1:0]    out_count_r, out_count_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [CMPW-1:0] pos_c, cnt_c, pos_m1;
  logic            ins_bad, ins_full, del_bad, ins_ok, del_ok;
  logic [ST_W-1:0] op_status;

  assign pos_c  = CMPW'(in_position);
  assign cnt_c  = CMPW'(count_r);
  assign pos_m1 = pos_c - CMPW'(1);

  assign ins_bad  = (pos_c == '0) || (pos_c > cnt_c + CMPW'(1));
  assign ins_full = (count_r == CW'(CAPACITY));
  assign del_bad  = (pos_c == '0) || (pos_c > cnt_c);
  assign ins_ok   = cmd.ins && !ins_bad && !ins_full;
  assign del_ok   = cmd.del && !del_bad;

  always_comb begin
    op_status = ST_OK;
    if (cmd.ins) begin
      if (ins_bad) begin
        op_status = ST_BAD_POS;
      end else if (ins_full) begin
        op_status = ST_FULL;
      end
    end else if (cmd.del && del_bad) begin
      op_status = ST_BAD_POS;
    end
  end

  // per-cell next value: insert shifts up, delete shifts down, dump rotates
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [VAL_W-1:0] above;
    logic signed [VAL_W-1:0] below;
    logic [CMPW-1:0]         jc;

    assign jc = CMPW'(j);

    if (j < CAPACITY - 1) begin : g_above
      assign above = slots_r[j+1];
    end else begin : g_top
      assign above = slots_r[j];
    end

    if (j > 0) begin : g_below
      assign below = slots_r[j-1];
    end else begin : g_bottom
      assign below = slots_r[j];
    end

    always_comb begin
      slots_nxt[j] = slots_r[j];
      if (ins_ok) begin
        if (jc == pos_m1) begin
          slots_nxt[j] = in_value;
        end else if (jc > pos_m1) begin
          slots_nxt[j] = below;
        end
      end else if (del_ok) begin
        if (jc >= pos_m1) begin
          slots_nxt[j] = above;
        end
      end else if (cmd.dump_step) begin
        if (jc + CMPW'(1) < cnt_c) begin
          slots_nxt[j] = above;
        end else if (jc + CMPW'(1) == cnt_c) begin
          slots_nxt[j] = slots_r[0];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (del_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.dump_start) begin
      idx_nxt = '0;
    end else if (cmd.dump_step) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  assign stat.out_valid  = out_valid_r;
  assign stat.count_zero = (count_r == '0);
  assign stat.dump_last  = (idx_r + CW'(1) == count_r);

  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;
    if (cmd.ins || cmd.del || cmd.single) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = op_status;
      out_element_nxt = '0;
      out_count_nxt   = CNT_OUT_W'(count_nxt);
      out_last_nxt    = 1'b1;
    end else if (cmd.dump_step) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = ST_OK;
      out_element_nxt = slots_r[0];
      out_count_nxt   = CNT_OUT_W'(count_r);
      out_last_nxt    = stat.dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r       <= slots_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_count   = out_count_r;
  assign out_last    = out_last_r;

endmodule

// ----- src/positional_list_insert_delete.sv -----
// top level of the positional list block: controller plus datapath
// depends on plid_pkg, plid_ctrl, plid_dp
// An ordered list of up to CAPACITY signed 32-bit elements held in a row of
// register cells. Insert and delete change the cells from their position up
// in the cycle they are transferred in, and their single result sits in the
// output register in the next cycle, so they run at one item per cycle when
// the output is not stalled. A dump has a start step, then one result per
// cycle unless the output stalls, as the cells rotate past the head cell,
// ending with the list in its original order. No new item is taken in a dump.
module positional_list_insert_delete import plid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_element,
  output logic [CNT_OUT_W-1:0]    out_count,
  output logic                    out_last
);

  plid_cmd_t  cmd;
  plid_stat_t stat;

  plid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .out_stall(out_stall),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  plid_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_position(in_position),
    .in_value   (in_value),
    .out_stall  (out_stall),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_element(out_element),
    .out_count  (out_count),
    .out_last   (out_last)
  );

endmodule

// ----- test/tb_positional_list_insert_delete.sv -----
// testbench for positional_list_insert_delete: directed table, then random insert/delete/dump
// depends on plid_pkg and the positional_list_insert_delete rtl
// results are checked field by field against an in-bench list predictor
`timescale 1ns / 1ps

module tb_positional_list_insert_delete;
  import plid_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int NUM_PHASES = 11;
  localparam int PHASE_ITEMS = 40;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRESSURE_AFTER = 150;
  localparam int PRESSURE_CYCLES = 300;
  localparam int NUM_DIR = 24;

  typedef enum int {GROW, SHRINK, MIXED} phase_kind_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] element;
    logic [CNT_OUT_W-1:0]    count;
    logic                    last;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [POS_W-1:0]     pos;
    logic [VAL_W-1:0]     val;
    logic                 typed;
    logic [ST_W-1:0]      st;
    logic [CNT_OUT_W-1:0] cnt;
  } list_vec_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_element;
  logic [CNT_OUT_W-1:0]    out_count;
  logic                    out_last;

  logic signed [VAL_W-1:0] list_cells [CAPACITY];
  int                      list_len;
  list_result_t            pending_list_results [$];
  int                      err_count;
  int                      cycles;
  bit                      sender_burst;

  list_vec_t dir_vecs [NUM_DIR] = '{
    '{OP_DUMP,   6'd0,  32'h0,        1'b1, ST_OK,      6'd0},
    '{OP_DELETE, 6'd1,  32'h0,        1'b1, ST_BAD_POS, 6'd0},
    '{OP_INSERT, 6'd0,  32'h5,        1'b1, ST_BAD_POS, 6'd0},
    '{OP_INSERT, 6'd2,  32'h5,        1'b1, ST_BAD_POS, 6'd0},
    '{OP_INSERT, 6'd1,  32'h7fffffff, 1'b1, ST_OK,      6'd1},
    '{OP_INSERT, 6'd1,  32'h80000000, 1'b1, ST_OK,      6'd2},
    '{OP_INSERT, 6'd3,  32'h0,        1'b1, ST_OK,      6'd3},
    '{OP_INSERT, 6'd2,  32'h55555555, 1'b1, ST_OK,      6'd4},
    '{OP_INSERT, 6'd63, 32'hffffffff, 1'b1, ST_BAD_POS, 6'd4},
    '{OP_DUMP,   6'd0,  32'h0,        1'b0, ST_OK,      6'd0},
    '{OP_DELETE, 6'd0,  32'h0,        1'b1, ST_BAD_POS, 6'd4},
    '{OP_DELETE, 6'd5,  32'h0,        1'b1, ST_BAD_POS, 6'd4},
    '{OP_DELETE, 6'd63, 32'hffffffff, 1'b1, ST_BAD_POS, 6'd4},
    '{OP_UNUSED, 6'd63, 32'hffffffff, 1'b1, ST_OK,      6'd4},
    '{OP_DELETE, 6'd4,  32'h0,        1'b1, ST_OK,      6'd3},
    '{OP_DELETE, 6'd1,  32'h0,        1'b1, ST_OK,      6'd2},
    '{OP_DUMP,   6'd63, 32'hffffffff, 1'b0, ST_OK,      6'd0},
    '{OP_INSERT, 6'd3,  32'haaaaaaaa, 1'b1, ST_OK,      6'd3},
    '{OP_UNUSED, 6'd0,  32'h0,        1'b1, ST_OK,      6'd3},
    '{OP_DELETE, 6'd2,  32'h0,        1'b1, ST_OK,      6'd2},
    '{OP_DUMP,   6'd0,  32'h0,        1'b0, ST_OK,      6'd0},
    '{OP_DELETE, 6'd1,  32'h0,        1'b1, ST_OK,      6'd1},
    '{OP_DELETE, 6'd1,  32'h0,        1'b1, ST_OK,      6'd0},
    '{OP_DUMP,   6'd0,  32'h0,        1'b1, ST_OK,      6'd0}
  };

  positional_list_insert_delete dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_position (in_position),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_element (out_element),
    .out_count   (out_count),
    .out_last    (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    err_count++;
  endtask

  // updates the list copy and queues the results one request causes
  task automatic compute_list_results(input logic [OP_W-1:0] op,
                                      input logic [POS_W-1:0] pos,
                                      input logic signed [VAL_W-1:0] val);
    list_result_t r;
    int p;
    int k;
    p = pos;
    r.status = ST_OK;
    r.element = '0;
    r.last = 1'b1;
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (k = list_len; k >= p; k--) list_cells[k] = list_cells[k-1];
          list_cells[p-1] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (k = p; k < list_len; k++) list_cells[k-1] = list_cells[k];
          list_len--;
        end
      end
      OP_DUMP: begin
        if (list_len > 0) begin
          for (k = 0; k < list_len; k++) begin
            r.element = list_cells[k];
            r.count = list_len[CNT_OUT_W-1:0];
            r.last = (k == list_len - 1);
            pending_list_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.count = list_len[CNT_OUT_W-1:0];
    pending_list_results.push_back(r);
  endtask

  // offers one request, waits for its transfer, then predicts
  task automatic send_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val, input logic typed,
                              input logic [ST_W-1:0] st, input logic [CNT_OUT_W-1:0] cnt);
    int gap;
    int q;
    list_result_t r;
    q = $urandom_range(0, 19);
    if (sender_burst || q < 12) gap = 0;
    else if (q < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_position <= pos;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    compute_list_results(op, pos, val);
    if (typed) begin
      r = pending_list_results.pop_back();
      r.status = st;
      r.element = '0;
      r.count = cnt;
      r.last = 1'b1;
      pending_list_results.push_back(r);
    end
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_positional_list_insert_delete: done, errors");
    $finish;
  end

  // result side: checks each transfer, drives out_stall
  initial begin
    int stall_left;
    int mode;
    int mode_left;
    int seen;
    bit pressure_done;
    list_result_t got;
    list_result_t want;
    stall_left = 0;
    mode = 0;
    mode_left = 0;
    seen = 0;
    pressure_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        got = '{out_status, out_element, out_count, out_last};
        seen++;
        if (pending_list_results.size() == 0) begin
          flag_error($sformatf("result with nothing due: status %0d element %0d count %0d",
                               got.status, got.element, got.count));
        end else begin
          want = pending_list_results.pop_front();
          if (got.status !== want.status)
            flag_error($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.element !== want.element)
            flag_error($sformatf("element got %0d want %0d", got.element, want.element));
          if (got.count !== want.count)
            flag_error($sformatf("count got %0d want %0d", got.count, want.count));
          if (got.last !== want.last)
            flag_error($sformatf("last got %0b want %0b", got.last, want.last));
        end
      end
      // one long hold-off so the block backs up into its input
      if (!pressure_done && seen >= PRESSURE_AFTER) begin
        pressure_done = 1;
        stall_left = PRESSURE_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rst_n && mode != 0 && $urandom_range(0, 99) < (mode == 1 ? 15 : 45)) begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    phase_kind_t kind;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int ph;
    int i;
    int r;
    err_count = 0;
    list_len = 0;
    sender_burst = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_INSERT;
    in_position <= '0;
    in_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_vecs[n])
      send_list_op(dir_vecs[n].op, dir_vecs[n].pos, dir_vecs[n].val, dir_vecs[n].typed,
                   dir_vecs[n].st, dir_vecs[n].cnt);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      kind = (ph == 0) ? GROW : phase_kind_t'($urandom_range(0, 2));
      sender_burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        case (kind)
          GROW:    op = r < 80 ? OP_INSERT : r < 90 ? OP_DELETE : r < 97 ? OP_DUMP : OP_UNUSED;
          SHRINK:  op = r < 15 ? OP_INSERT : r < 88 ? OP_DELETE : r < 97 ? OP_DUMP : OP_UNUSED;
          default: op = r < 45 ? OP_INSERT : r < 85 ? OP_DELETE : r < 97 ? OP_DUMP : OP_UNUSED;
        endcase
        if ($urandom_range(0, 9) == 0 || op == OP_DUMP || op == OP_UNUSED ||
            (op == OP_DELETE && list_len == 0))
          pos = $urandom_range(0, 63);
        else if (op == OP_INSERT)
          pos = $urandom_range(1, list_len + 1);
        else
          pos = $urandom_range(1, list_len);
        case ($urandom_range(0, 15))
          0:       val = 32'h7fffffff;
          1:       val = 32'h80000000;
          2:       val = 32'h0;
          3:       val = 32'hffffffff;
          default: val = $urandom;
        endcase
        send_list_op(op, pos, val, 1'b0, ST_OK, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_list_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_positional_list_insert_delete: done, clean");
    end else begin
      $display("tb_positional_list_insert_delete: done, errors");
    end
    $finish;
  end

endmodule
